>>> design/lru_key_value_cache_unit_defines.svh
// assertion macros shared by the lru key-value cache checker
`ifndef LRU_KEY_VALUE_CACHE_UNIT_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define LKVC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lkvc assertion failed");

// next-cycle implication, disabled while reset is asserted
`define LKVC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lkvc assertion failed");

`endif

>>> design/lkvc_pkg.sv
// shared types and constants for the lru key-value cache
`default_nettype none

package lkvc_pkg;

    localparam int ENTRIES_DEFAULT = 16;
    localparam int KEY_W           = 32;
    localparam int VAL_W           = 32;
    localparam int CAP_W           = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic ACT_GET = 1'b0;
    localparam logic ACT_PUT = 1'b1;

    localparam logic [VAL_W-1:0] MISS_VALUE = '1;

    typedef struct packed {
        logic capture;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic is_get;
    } t_stat;

endpackage

`default_nettype wire

>>> design/lkvc_ctrl.sv
// control state machine: accept, commit and output handshake
`default_nettype none

module lkvc_ctrl (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  wire logic         i_out_stall,
    input  wire lkvc_pkg::t_stat i_stat,
    output lkvc_pkg::t_cmd    o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_COMMIT = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_can_commit;

    assign w_can_commit = !(i_stat.is_get && r_out_valid && i_out_stall);

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (w_can_commit) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_out_valid = (r_out_valid && i_out_stall) || (o_cmd.commit && i_stat.is_get);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

>>> design/lkvc_datapath.sv
// key cam, value memory, recency ranks and occupancy
`default_nettype none

module lkvc_datapath #(
    parameter int ENTRIES = lkvc_pkg::ENTRIES_DEFAULT
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire lkvc_pkg::t_cmd              i_cmd,
    output lkvc_pkg::t_stat                  o_stat,
    input  wire logic                        i_cfg_we,
    input  wire logic [lkvc_pkg::CAP_W-1:0]  i_cfg_data,
    input  wire logic                        i_action,
    input  wire logic [lkvc_pkg::KEY_W-1:0]  i_key,
    input  wire logic [lkvc_pkg::VAL_W-1:0]  i_value,
    output logic                             o_hit,
    output logic [lkvc_pkg::VAL_W-1:0]       o_read_value
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int EW = (CW > lkvc_pkg::CAP_W) ? CW : lkvc_pkg::CAP_W;

    logic [lkvc_pkg::KEY_W-1:0] r_keys [ENTRIES];
    logic [lkvc_pkg::VAL_W-1:0] r_mem  [ENTRIES];
    logic [ENTRIES-1:0]         r_valid;
    logic [IW-1:0]              r_age  [ENTRIES];
    logic [CW-1:0]              r_occ;
    logic [lkvc_pkg::CAP_W-1:0] r_cap;

    // captured item and lookup results
    logic                       r_action;
    logic [lkvc_pkg::KEY_W-1:0] r_key_in;
    logic [lkvc_pkg::VAL_W-1:0] r_value_in;
    logic                       r_hit;
    logic [IW-1:0]              r_hit_idx;
    logic [IW-1:0]              r_hit_age;
    logic                       r_have_free;
    logic [IW-1:0]              r_free_idx;
    logic [IW-1:0]              r_victim_idx;

    logic                       r_o_hit;
    logic [lkvc_pkg::VAL_W-1:0] r_o_value;

    logic [ENTRIES-1:0] w_match, w_free, w_low_free, w_victim;
    logic [IW-1:0]      w_hit_idx, w_hit_age, w_free_idx, w_victim_idx, w_oldest;
    logic [EW-1:0]      w_cap, w_eff, w_occ;
    logic               w_evict;
    logic [IW-1:0]      w_slot;

    assign w_oldest   = IW'(r_occ - CW'(1));
    assign w_free     = ~r_valid;
    assign w_low_free = w_free & (~w_free + ENTRIES'(1));

    always_comb begin
        w_hit_idx    = '0;
        w_hit_age    = '0;
        w_free_idx   = '0;
        w_victim_idx = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            w_match[i]  = r_valid[i] && (r_keys[i] == i_key);
            w_victim[i] = r_valid[i] && (r_age[i] == w_oldest);
            if (w_match[i]) begin
                w_hit_idx = w_hit_idx | IW'(i);
                w_hit_age = w_hit_age | r_age[i];
            end
            if (w_low_free[i]) begin
                w_free_idx = w_free_idx | IW'(i);
            end
            if (w_victim[i]) begin
                w_victim_idx = w_victim_idx | IW'(i);
            end
        end
    end

    // effective capacity: zero acts as one, clipped to the table size
    always_comb begin
        w_cap = EW'(r_cap);
        w_occ = EW'(r_occ);
        if (w_cap == '0) begin
            w_eff = EW'(1);
        end else if (w_cap > EW'(ENTRIES)) begin
            w_eff = EW'(ENTRIES);
        end else begin
            w_eff = w_cap;
        end
        w_evict = (w_occ >= w_eff);
        if (w_evict) begin
            w_slot = (r_have_free && (r_free_idx < r_victim_idx)) ? r_free_idx : r_victim_idx;
        end else begin
            w_slot = r_free_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action     <= i_action;
            r_key_in     <= i_key;
            r_value_in   <= i_value;
            r_hit        <= |w_match;
            r_hit_idx    <= w_hit_idx;
            r_hit_age    <= w_hit_age;
            r_have_free  <= |w_free;
            r_free_idx   <= w_free_idx;
            r_victim_idx <= w_victim_idx;
        end
    end

    // value memory and output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            if (r_action == lkvc_pkg::ACT_GET) begin
                r_o_hit   <= r_hit;
                r_o_value <= r_hit ? r_mem[r_hit_idx] : lkvc_pkg::MISS_VALUE;
            end else if (r_hit) begin
                r_mem[r_hit_idx] <= r_value_in;
            end else begin
                r_mem[w_slot] <= r_value_in;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && r_action == lkvc_pkg::ACT_PUT && !r_hit) begin
            r_keys[w_slot] <= r_key_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_occ   <= '0;
            r_cap   <= lkvc_pkg::CAP_RESET;
            for (int i = 0; i < ENTRIES; i++) begin
                r_age[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
            if (i_cmd.commit) begin
                if (r_hit) begin
                    // touch: younger entries age by one
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (IW'(i) == r_hit_idx) begin
                            r_age[i] <= '0;
                        end else if (r_valid[i] && (r_age[i] < r_hit_age)) begin
                            r_age[i] <= r_age[i] + IW'(1);
                        end
                    end
                end else if (r_action == lkvc_pkg::ACT_PUT) begin
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (IW'(i) == w_slot) begin
                            r_valid[i] <= 1'b1;
                            r_age[i]   <= '0;
                        end else if (w_evict && IW'(i) == r_victim_idx) begin
                            r_valid[i] <= 1'b0;
                            r_age[i]   <= '0;
                        end else if (r_valid[i]) begin
                            r_age[i] <= r_age[i] + IW'(1);
                        end
                    end
                    if (!w_evict) begin
                        r_occ <= r_occ + CW'(1);
                    end
                end
            end
        end
    end

    assign o_stat.is_get = (r_action == lkvc_pkg::ACT_GET);
    assign o_hit         = r_o_hit;
    assign o_read_value  = r_o_value;

endmodule

`default_nettype wire

>>> design/lru_key_value_cache_unit.sv
// lru key-value cache: one item at a time, accept edge then commit edge
// a get's result beat is valid right after the commit edge
// a new item is taken only once the last has committed: lookup, then read-modify-write of ranks and value memory
// a get waits in commit while an earlier result beat is still stalled
// reset (synchronous, active low) clears valid bits, ranks, count; capacity returns to 16
`default_nettype none

module lru_key_value_cache_unit #(
    parameter int ENTRIES = lkvc_pkg::ENTRIES_DEFAULT
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [lkvc_pkg::CAP_W-1:0]        i_cfg_data,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic                              i_action,
    input  wire logic signed [lkvc_pkg::KEY_W-1:0] i_key,
    input  wire logic signed [lkvc_pkg::VAL_W-1:0] i_value,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic                                   o_hit,
    output logic signed [lkvc_pkg::VAL_W-1:0]      o_read_value
);

    lkvc_pkg::t_cmd  w_cmd;
    lkvc_pkg::t_stat w_stat;
    logic [lkvc_pkg::VAL_W-1:0] w_read_value;

    lkvc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    lkvc_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_action     (i_action),
        .i_key        (i_key),
        .i_value      (i_value),
        .o_hit        (o_hit),
        .o_read_value (w_read_value)
    );

    assign o_read_value = w_read_value;

endmodule

`default_nettype wire

>>> design/lkvc_checker.sv
// port-level checker for the lru key-value cache, bound to the top level
`default_nettype none
`include "lru_key_value_cache_unit_defines.svh"

module lkvc_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_in_valid,
    input wire logic                       o_in_stall,
    input wire logic                       o_out_valid,
    input wire logic                       i_out_stall,
    input wire logic                       o_hit,
    input wire logic [lkvc_pkg::VAL_W-1:0] o_read_value
);

    // result beat held while stalled
    `LKVC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)

    // one item at a time: an accepted beat blocks the next cycle
    `LKVC_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)

    // a miss always reads all ones
    `LKVC_ASSERT_IMPLY(a_miss_value, i_clk, i_rst_n, o_out_valid && !o_hit, o_read_value == lkvc_pkg::MISS_VALUE)

endmodule

bind lru_key_value_cache_unit lkvc_checker u_lkvc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_hit        (o_hit),
    .o_read_value (o_read_value)
);

`default_nettype wire

>>> verif/tb.sv
// testbench for lru_key_value_cache_unit: lru predictor, scoreboard, random traffic with stalls
`default_nettype none

module tb;

    import lkvc_pkg::*;

    localparam int SLOTS      = ENTRIES_DEFAULT;
    localparam int HOLD_BEATS = 120;
    localparam int N_PHASES   = 10;
    localparam int PHASE_LEN  = 155;

    typedef struct packed {
        logic             hit;
        logic [VAL_W-1:0] data;
    } lookup_t;

    class lru_cache_scoreboard;
        logic [KEY_W-1:0] slot_key [SLOTS];
        logic [VAL_W-1:0] slot_val [SLOTS];
        bit               slot_used[SLOTS];
        int unsigned      slot_rank[SLOTS];
        int unsigned      fill;
        logic [CAP_W-1:0] cap_reg;
        lookup_t          lookup_q[$];
        int               errors, n_gets, n_hits, n_puts, n_evicts;

        function new();
            for (int i = 0; i < SLOTS; i++) begin
                slot_key[i]  = '0;
                slot_val[i]  = '0;
                slot_used[i] = 1'b0;
                slot_rank[i] = 0;
            end
            fill    = 0;
            cap_reg = CAP_RESET;
        endfunction

        function void set_capacity(logic [CAP_W-1:0] c);
            cap_reg = c;
        endfunction

        function int unsigned limit();
            int unsigned c;
            c = cap_reg;
            if (c == 0) c = 1;
            if (c > SLOTS) c = SLOTS;
            return c;
        endfunction

        function void promote(int s);
            int unsigned r;
            r = slot_rank[s];
            for (int i = 0; i < SLOTS; i++)
                if (slot_used[i] && i != s && slot_rank[i] < r) slot_rank[i]++;
            slot_rank[s] = 0;
        endfunction

        function void retire_oldest();
            int victim;
            victim = -1;
            for (int i = 0; i < SLOTS; i++)
                if (slot_used[i] && (victim < 0 || slot_rank[i] > slot_rank[victim])) victim = i;
            if (victim >= 0) begin
                slot_used[victim] = 1'b0;
                slot_rank[victim] = 0;
                if (fill > 0) fill--;
                n_evicts++;
            end
        endfunction

        function void note_input(logic act, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
            int s, free_slot;
            lookup_t r;
            s = -1;
            for (int i = 0; i < SLOTS; i++)
                if (s < 0 && slot_used[i] && slot_key[i] == k) s = i;
            if (act == ACT_GET) begin
                n_gets++;
                if (s >= 0) begin
                    promote(s);
                    r.hit  = 1'b1;
                    r.data = slot_val[s];
                    n_hits++;
                end else begin
                    r.hit  = 1'b0;
                    r.data = MISS_VALUE;
                end
                lookup_q.push_back(r);
                return;
            end
            n_puts++;
            if (s >= 0) begin
                slot_val[s] = v;
                promote(s);
                return;
            end
            if (fill >= limit()) retire_oldest();
            free_slot = -1;
            for (int i = 0; i < SLOTS; i++)
                if (free_slot < 0 && !slot_used[i]) free_slot = i;
            if (free_slot < 0) return;
            for (int i = 0; i < SLOTS; i++)
                if (slot_used[i]) slot_rank[i]++;
            slot_key[free_slot]  = k;
            slot_val[free_slot]  = v;
            slot_used[free_slot] = 1'b1;
            slot_rank[free_slot] = 0;
            fill++;
        endfunction

        function void check_result(logic hit, logic [VAL_W-1:0] data);
            lookup_t exp_r;
            if (lookup_q.size() == 0) begin
                errors++;
                $error("unexpected result beat: hit=%0b read_value=%h", hit, data);
                return;
            end
            exp_r = lookup_q.pop_front();
            if (hit !== exp_r.hit) begin
                errors++;
                $error("hit: expected %0b, got %0b", exp_r.hit, hit);
            end
            if (data !== exp_r.data) begin
                errors++;
                $error("read_value: expected %h, got %h", exp_r.data, data);
            end
        endfunction

        function int pending();
            return lookup_q.size();
        endfunction
    endclass

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       i_cfg_we;
    logic [CAP_W-1:0]           i_cfg_data;
    logic                       i_in_valid;
    logic                       o_in_stall;
    logic                       i_action;
    logic signed [KEY_W-1:0]    i_key;
    logic signed [VAL_W-1:0]    i_value;
    logic                       o_out_valid;
    logic                       i_out_stall;
    logic                       o_hit;
    logic signed [VAL_W-1:0]    o_read_value;

    lru_cache_scoreboard sb = new();

    bit gaps_on;
    bit hold_request;
    int burst_left;
    int n_cfg;

    always #5 i_clk = ~i_clk;

    lru_key_value_cache_unit u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_action     (i_action),
        .i_key        (i_key),
        .i_value      (i_value),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_hit        (o_hit),
        .o_read_value (o_read_value)
    );

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0)
            sb.check_result(o_hit, o_read_value);
    end

    // receiver stall pattern, with one long hold-off on request
    initial begin
        int mode, seg_left, tick;
        mode     = 0;
        seg_left = 0;
        tick     = 0;
        i_out_stall <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_BEATS) @(posedge i_clk);
            end
            if (seg_left == 0) begin
                mode     = $urandom_range(0, 3);
                seg_left = $urandom_range(20, 200);
            end
            seg_left--;
            tick++;
            case (mode)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(0, 3) == 0);
                2: i_out_stall <= ((tick % 7) < 3);
                default: i_out_stall <= ($urandom_range(0, 1) == 1);
            endcase
        end
    end

    task automatic send_beat(input logic act, input logic [KEY_W-1:0] k,
                             input logic [VAL_W-1:0] v);
        int gap;
        if (gaps_on && burst_left <= 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_action   <= act;
        i_key      <= k;
        i_value    <= v;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        sb.note_input(act, k, v);
    endtask

    // stop offering and wait for every pending result plus the commit latency
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] c);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= c;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_capacity(c);
        n_cfg++;
    endtask

    initial begin
        logic [CAP_W-1:0] phase_caps[N_PHASES];
        logic [KEY_W-1:0] key_pool[$];
        logic [KEY_W-1:0] k;
        logic [VAL_W-1:0] v;
        int pool_n;

        phase_caps = '{5'd31, 5'd1, 5'd0, 5'd5, 5'd17, 5'd3, 5'd16, 5'd8, 5'd2, 5'd12};
        gaps_on      = 1'b1;
        hold_request = 1'b0;
        burst_left   = 0;
        n_cfg        = 0;

        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_data <= '0;
        i_in_valid <= 1'b0;
        i_action   <= ACT_GET;
        i_key      <= '0;
        i_value    <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // extremes, overwrite, miss, stored value equal to the miss pattern
        send_beat(ACT_PUT, 32'h8000_0000, 32'h7fff_ffff);
        send_beat(ACT_PUT, 32'h7fff_ffff, 32'h8000_0000);
        send_beat(ACT_GET, 32'h8000_0000, 32'h0);
        send_beat(ACT_GET, 32'h7fff_ffff, 32'hffff_ffff);
        send_beat(ACT_GET, 32'h0000_0000, 32'h0);
        send_beat(ACT_PUT, 32'hffff_ffff, 32'hffff_ffff);
        send_beat(ACT_GET, 32'hffff_ffff, 32'h0);
        send_beat(ACT_PUT, 32'h8000_0000, 32'h0000_0000);
        send_beat(ACT_GET, 32'h8000_0000, 32'h0);
        send_beat(ACT_PUT, 32'h0000_0000, 32'h5555_5555);
        send_beat(ACT_GET, 32'h0000_0000, 32'h0);
        send_beat(ACT_GET, 32'haaaa_aaaa, 32'h0);

        // capacity below occupancy: each new key evicts one
        write_capacity(5'd2);
        send_beat(ACT_PUT, 32'h0000_0001, 32'h1111_1111);
        send_beat(ACT_PUT, 32'h0000_0002, 32'h2222_2222);
        send_beat(ACT_GET, 32'h7fff_ffff, 32'h0);
        send_beat(ACT_GET, 32'h0000_0001, 32'h0);
        send_beat(ACT_PUT, 32'h0000_0003, 32'h3333_3333);
        send_beat(ACT_GET, 32'h0000_0001, 32'h0);
        send_beat(ACT_GET, 32'h0000_0002, 32'h0);
        send_beat(ACT_GET, 32'h0000_0003, 32'h0);

        for (int p = 0; p < N_PHASES; p++) begin
            write_capacity(phase_caps[p]);
            pool_n = sb.limit() + $urandom_range(1, 6);
            key_pool.delete();
            for (int i = 0; i < pool_n; i++) begin
                case ($urandom_range(0, 9))
                    0: key_pool.push_back(32'h8000_0000 + $urandom_range(0, 3));
                    1: key_pool.push_back(32'h7fff_ffff - $urandom_range(0, 3));
                    default: key_pool.push_back($urandom);
                endcase
            end
            gaps_on = (p != 6);
            if (p == 6) hold_request = 1'b1;
            for (int n = 0; n < PHASE_LEN; n++) begin
                if ($urandom_range(0, 9) == 0) k = $urandom;
                else k = key_pool[$urandom_range(0, pool_n - 1)];
                case ($urandom_range(0, 15))
                    0: v = 32'hffff_ffff;
                    1: v = 32'h8000_0000;
                    2: v = 32'h7fff_ffff;
                    default: v = $urandom;
                endcase
                send_beat(($urandom_range(0, 1) == 1) ? ACT_PUT : ACT_GET, k, v);
            end
        end

        drain();
        $display("run covered %0d gets (%0d hits) and %0d puts with %0d evictions",
                 sb.n_gets, sb.n_hits, sb.n_puts, sb.n_evicts);
        $display("across %0d capacity writes, including 0, 1, 16, 17 and 31", n_cfg);
        if (sb.errors == 0) begin
            $display("lru_key_value_cache_unit: match");
        end else begin
            $display("lru_key_value_cache_unit: mismatch");
        end
        $finish;
    end

    // watchdog
    initial begin
        #3_000_000;
        $display("timeout with %0d results pending", sb.pending());
        $display("lru_key_value_cache_unit: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
